### sv/stlpq_pkg.sv
// Shared types and constants for the stable three-level priority queue.
// No dependencies; imported by every module of the block.
package stlpq_pkg;

    localparam int NUM_CLASSES     = 3;
    localparam int CLS_W           = 2;
    localparam int HANDLE_W        = 16;
    localparam int COUNT_W         = 6;
    localparam int DEF_CLASS_DEPTH = 16;
    localparam int DEF_HANDLE_BITS = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [CLS_W-1:0] CLS_ECONOMY  = 2'd0;
    localparam logic [CLS_W-1:0] CLS_STANDARD = 2'd1;
    localparam logic [CLS_W-1:0] CLS_INSTANT  = 2'd2;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    // Per-beat result information, handed from the controller to the result register
    typedef struct packed {
        status_t              status;
        logic [CLS_W-1:0]     popped_class;
        logic [COUNT_W-1:0]   entry_count;
    } result_info_t;

endpackage

### sv/stlpq_store.sv
// Handle memory: one ring of CLASS_DEPTH slots per class, single port.
// Depends on stlpq_pkg for the class count.
module stlpq_store import stlpq_pkg::*; #(
    parameter int CLASS_DEPTH = DEF_CLASS_DEPTH,
    parameter int HANDLE_BITS = DEF_HANDLE_BITS,
    parameter int ADDR_W      = $clog2(NUM_CLASSES * CLASS_DEPTH)
) (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic                   rd_en,
    input  logic [ADDR_W-1:0]      addr,
    input  logic [HANDLE_BITS-1:0] wr_data,
    output logic [HANDLE_BITS-1:0] rd_data
);

    localparam int ENTRIES = NUM_CLASSES * CLASS_DEPTH;

    logic [HANDLE_BITS-1:0] mem [ENTRIES];
    logic [HANDLE_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/stlpq_ctrl.sv
// Per-class ring pointers and fill counts; decides each beat and drives the memory port.
// Depends on stlpq_pkg.
module stlpq_ctrl import stlpq_pkg::*; #(
    parameter int CLASS_DEPTH = DEF_CLASS_DEPTH,
    parameter int ADDR_W      = $clog2(NUM_CLASSES * CLASS_DEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              opcode,
    input  logic [CLS_W-1:0]  priority_class,
    output logic              mem_wr_en,
    output logic              mem_rd_en,
    output logic [ADDR_W-1:0] mem_addr,
    output result_info_t      info
);

    localparam int PTR_W  = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int FILL_W = $clog2(CLASS_DEPTH + 1);
    localparam int SUM_W  = PTR_W + 1;
    localparam int TOT_W  = $clog2(NUM_CLASSES * CLASS_DEPTH + 1);

    logic [PTR_W-1:0]  head_reg  [NUM_CLASSES];
    logic [PTR_W-1:0]  head_next [NUM_CLASSES];
    logic [FILL_W-1:0] fill_reg  [NUM_CLASSES];
    logic [FILL_W-1:0] fill_next [NUM_CLASSES];
    logic [TOT_W-1:0]  total_reg;
    logic [TOT_W-1:0]  total_next;

    logic [CLS_W-1:0]  ins_cls;
    logic [CLS_W-1:0]  pop_cls;
    logic              any_held;
    logic [CLS_W-1:0]  sel;
    logic [PTR_W-1:0]  head_sel;
    logic [FILL_W-1:0] fill_sel;
    logic              full;
    logic [SUM_W-1:0]  tail_sum;
    logic [PTR_W-1:0]  tail;
    logic [PTR_W-1:0]  head_inc;
    logic [PTR_W-1:0]  slot;
    logic [ADDR_W-1:0] base;
    logic              is_insert;
    logic              do_ins;
    logic              do_pop;

    // class three saturates to the top class
    assign ins_cls = (priority_class > CLS_INSTANT) ? CLS_INSTANT : priority_class;

    always_comb begin
        pop_cls  = CLS_ECONOMY;
        any_held = 1'b1;
        priority if (fill_reg[CLS_INSTANT] != '0) begin
            pop_cls = CLS_INSTANT;
        end else if (fill_reg[CLS_STANDARD] != '0) begin
            pop_cls = CLS_STANDARD;
        end else if (fill_reg[CLS_ECONOMY] != '0) begin
            pop_cls = CLS_ECONOMY;
        end else begin
            any_held = 1'b0;
        end
    end

    assign is_insert = (opcode == OP_INSERT);
    assign sel       = is_insert ? ins_cls : pop_cls;
    assign head_sel  = head_reg[sel];
    assign fill_sel  = fill_reg[sel];
    assign full      = (fill_sel == FILL_W'(CLASS_DEPTH));

    // head + fill stays below twice the depth when not full: one compare-subtract wraps it
    assign tail_sum = SUM_W'(head_sel) + SUM_W'(fill_sel);
    assign tail     = (tail_sum >= SUM_W'(CLASS_DEPTH))
                    ? PTR_W'(tail_sum - SUM_W'(CLASS_DEPTH)) : PTR_W'(tail_sum);
    assign head_inc = (head_sel == PTR_W'(CLASS_DEPTH - 1)) ? '0 : head_sel + 1'b1;
    assign slot     = is_insert ? tail : head_sel;

    always_comb begin
        unique case (sel)
            CLS_ECONOMY:  base = '0;
            CLS_STANDARD: base = ADDR_W'(CLASS_DEPTH);
            default:      base = ADDR_W'(2 * CLASS_DEPTH);
        endcase
    end

    assign do_ins    = accept && is_insert && !full;
    assign do_pop    = accept && !is_insert && any_held;
    assign mem_wr_en = do_ins;
    assign mem_rd_en = do_pop;
    assign mem_addr  = base + ADDR_W'(slot);

    always_comb begin
        head_next  = head_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        if (do_ins) begin
            fill_next[sel] = fill_sel + 1'b1;
            total_next     = total_reg + 1'b1;
        end else if (do_pop) begin
            head_next[sel] = head_inc;
            fill_next[sel] = fill_sel - 1'b1;
            total_next     = total_reg - 1'b1;
        end
    end

    always_comb begin
        if (is_insert) begin
            info.status = full ? ST_REJECTED : ST_INSERTED;
        end else begin
            info.status = any_held ? ST_POPPED : ST_EMPTY;
        end
        info.popped_class = (!is_insert && any_held) ? sel : CLS_ECONOMY;
        info.entry_count  = COUNT_W'(total_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_reg[c] <= '0;
                fill_reg[c] <= '0;
            end
            total_reg <= '0;
        end else begin
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg[CLS_ECONOMY] <= FILL_W'(CLASS_DEPTH)
        && fill_reg[CLS_STANDARD] <= FILL_W'(CLASS_DEPTH)
        && fill_reg[CLS_INSTANT] <= FILL_W'(CLASS_DEPTH))
        else $error("class fill beyond ring depth");

    a_total_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg == TOT_W'(fill_reg[CLS_ECONOMY]) + TOT_W'(fill_reg[CLS_STANDARD])
                     + TOT_W'(fill_reg[CLS_INSTANT]))
        else $error("total count out of step with class fills");

    a_top_first: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_insert && fill_reg[CLS_INSTANT] != '0 |-> mem_rd_en
        && info.popped_class == CLS_INSTANT)
        else $error("pop skipped a non-empty instant class");

    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_insert && full |=> total_reg == $past(total_reg))
        else $error("rejected insert changed the count");

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg[CLS_ECONOMY] < PTR_W'(CLASS_DEPTH - 1) + 1'b1 || CLASS_DEPTH == (1 << PTR_W))
        else $error("ring head beyond depth");

endmodule

### sv/stable_three_level_priority_queue_core.sv
// Stable three-class priority queue. One command beat (insert or pop) is accepted per clock
// while the result register is free or being drained; its result beat appears in the following
// cycle from a result register, so the sustained rate is one item per cycle while m_ready holds.
// The rate is set by the single-port handle memory: an insert writes one slot at its class tail
// and a pop reads one slot at the head of the highest non-empty class, both in the accepting cycle.
// Each class holds CLASS_DEPTH entries; an insert into a full class returns status 3 and changes
// nothing, a pop on an empty queue returns status 2. Class value three is taken as class two.
// No clearing pass is needed after reset. Depends on stlpq_pkg, stlpq_ctrl and stlpq_store.
module stable_three_level_priority_queue_core import stlpq_pkg::*; #(
    parameter int CLASS_DEPTH = DEF_CLASS_DEPTH,
    parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic [HANDLE_W-1:0] s_item_handle,
    input  logic [CLS_W-1:0]    s_priority_class,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [HANDLE_W-1:0] m_popped_handle,
    output logic [CLS_W-1:0]    m_popped_class,
    output logic [COUNT_W-1:0]  m_entry_count
);

    localparam int ADDR_W = $clog2(NUM_CLASSES * CLASS_DEPTH);

    logic                   accept;
    logic                   mem_wr_en;
    logic                   mem_rd_en;
    logic [ADDR_W-1:0]      mem_addr;
    logic [HANDLE_BITS-1:0] rd_data;
    result_info_t           info;
    result_info_t           info_reg;
    logic                   m_valid_reg;
    logic                   m_valid_next;

    // result register frees up in the same cycle it is drained
    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    stlpq_ctrl #(
        .CLASS_DEPTH (CLASS_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .opcode         (s_opcode),
        .priority_class (s_priority_class),
        .mem_wr_en      (mem_wr_en),
        .mem_rd_en      (mem_rd_en),
        .mem_addr       (mem_addr),
        .info           (info)
    );

    stlpq_store #(
        .CLASS_DEPTH (CLASS_DEPTH),
        .HANDLE_BITS (HANDLE_BITS),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .rd_en   (mem_rd_en),
        .addr    (mem_addr),
        .wr_data (HANDLE_BITS'(s_item_handle)),
        .rd_data (rd_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            info_reg <= info;
        end
    end

    // memory read data is only reloaded on an accepted pop, so it holds through a stall
    assign m_valid         = m_valid_reg;
    assign m_status        = info_reg.status;
    assign m_popped_class  = info_reg.popped_class;
    assign m_entry_count   = info_reg.entry_count;
    assign m_popped_handle = (info_reg.status == ST_POPPED) ? HANDLE_W'(rd_data) : '0;

endmodule
